>>> hw/rtl/brbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brbf_pkg
// Shared types and constants for the bright row band finder.
// ----------------------------------------------------------------------------
package brbf_pkg;

  // Default raster limits.
  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 1024;

  // Fixed field widths.
  localparam int PIX_W   = 8;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int POS_W   = 10;
  localparam int HGT_W   = 11;
  localparam int SCORE_W = 21;
  localparam int STAT_W  = 2;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  // Register reset values.
  localparam logic [PIX_W-1:0] GRAY_THRESHOLD_RST  = 8'd250;
  localparam logic [CFG_W-1:0] MIN_ROW_COUNT_RST   = 11'd15;
  localparam logic [CFG_W-1:0] MAX_ROW_COUNT_RST   = 11'd400;
  localparam logic [CFG_W-1:0] MAX_BAND_HEIGHT_RST = 11'd60;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRAY_THRESHOLD  = 2'd0,
    REG_MIN_ROW_COUNT   = 2'd1,
    REG_MAX_ROW_COUNT   = 2'd2,
    REG_MAX_BAND_HEIGHT = 2'd3
  } brbf_reg_t;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_BAND  = 2'd1,
    STATUS_TOO_TALL = 2'd2
  } brbf_status_t;

  typedef struct packed {
    logic [PIX_W-1:0] gray_threshold;
    logic [CFG_W-1:0] min_row_count;
    logic [CFG_W-1:0] max_row_count;
    logic [CFG_W-1:0] max_band_height;
  } brbf_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_end;
    logic             frame_end;
  } brbf_item_t;

  typedef struct packed {
    brbf_status_t       status;
    logic [POS_W-1:0]   band_start;
    logic [POS_W-1:0]   band_end;
    logic [HGT_W-1:0]   band_height;
    logic [SCORE_W-1:0] band_score;
  } brbf_result_t;

endpackage

>>> hw/rtl/brbf_band_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brbf_band_core
// Per-row bright counting, band tracking and the frame-end band report.
// ----------------------------------------------------------------------------
module brbf_band_core import brbf_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         advance,
  input  brbf_item_t   item,
  input  brbf_cfg_t    cfg,
  output brbf_result_t result
);

  localparam int CNT_W = $clog2(MAX_COLS + 1);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int DIF_W = ROW_W + 1;
  localparam int HCM_W = (DIF_W + 1 > HGT_W) ? DIF_W + 1 : HGT_W;

  localparam logic [CNT_W-1:0] COLS_LIM = CNT_W'(MAX_COLS);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_ROWS - 1);
  localparam logic [DIF_W-1:0] ROWS_N   = DIF_W'(MAX_ROWS);

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic               in_band_r, in_band_nxt;
  logic [ROW_W-1:0]   open_start_r, open_start_nxt;
  logic [SCORE_W-1:0] open_score_r, open_score_nxt;
  logic [ROW_W-1:0]   best_start_r, best_start_nxt;
  logic [ROW_W-1:0]   best_end_r, best_end_nxt;
  logic [SCORE_W-1:0] best_score_r, best_score_nxt;
  logic               have_best_r, have_best_nxt;

  logic [CNT_W-1:0]   cnt_cur;
  logic               row_valid;
  logic [ROW_W-1:0]   prev_row;
  logic [SCORE_W:0]   open_sum;
  logic [SCORE_W-1:0] band_start_score;
  logic [ROW_W-1:0]   band_start_row;
  logic               cl_fire, cl_take, fin_have;
  logic [ROW_W-1:0]   cl_start, cl_end, fin_start, fin_end;
  logic [SCORE_W-1:0] cl_score, fin_score;
  logic [DIF_W-1:0]   diff;
  logic [DIF_W:0]     height;

  always_comb begin
    // Bright count including the current pixel, saturating at the column limit.
    cnt_cur = cnt_r;
    if (item.pixel >= cfg.gray_threshold && cnt_r < COLS_LIM) begin
      cnt_cur = cnt_r + 1'b1;
    end
    row_valid = (CMP_W'(cnt_cur) >= CMP_W'(cfg.min_row_count)) &&
                (CMP_W'(cnt_cur) <= CMP_W'(cfg.max_row_count));
    prev_row  = (row_r == '0) ? ROW_LAST : row_r - 1'b1;

    open_sum = {1'b0, open_score_r} + (SCORE_W + 1)'(cnt_cur);
    if (in_band_r) begin
      band_start_row   = open_start_r;
      band_start_score = open_sum[SCORE_W] ? SCORE_MAX : open_sum[SCORE_W-1:0];
    end else begin
      band_start_row   = row_r;
      band_start_score = SCORE_W'(cnt_cur);
    end

    // A band closes either on an invalid row or when the frame ends inside it.
    cl_fire  = 1'b0;
    cl_start = open_start_r;
    cl_end   = prev_row;
    cl_score = open_score_r;
    if (row_valid && item.frame_end) begin
      cl_fire  = 1'b1;
      cl_start = band_start_row;
      cl_end   = row_r;
      cl_score = band_start_score;
    end else if (!row_valid && in_band_r) begin
      cl_fire  = 1'b1;
    end
    cl_take   = cl_fire && (!have_best_r || cl_score > best_score_r);
    fin_have  = have_best_r || cl_fire;
    fin_start = cl_take ? cl_start : best_start_r;
    fin_end   = cl_take ? cl_end   : best_end_r;
    fin_score = cl_take ? cl_score : best_score_r;

    // Height modulo the row count, plus one.
    if (fin_end >= fin_start) begin
      diff = DIF_W'(fin_end) - DIF_W'(fin_start);
    end else begin
      diff = DIF_W'(fin_end) + ROWS_N - DIF_W'(fin_start);
    end
    height = (DIF_W + 1)'(diff) + 1'b1;

    if (!fin_have) begin
      result = '0;
      result.status = STATUS_NO_BAND;
    end else begin
      result.status      = (HCM_W'(height) > HCM_W'(cfg.max_band_height)) ?
                           STATUS_TOO_TALL : STATUS_OK;
      result.band_start  = POS_W'(fin_start);
      result.band_end    = POS_W'(fin_end);
      result.band_height = HGT_W'(height);
      result.band_score  = fin_score;
    end

    cnt_nxt        = cnt_r;
    row_nxt        = row_r;
    in_band_nxt    = in_band_r;
    open_start_nxt = open_start_r;
    open_score_nxt = open_score_r;
    best_start_nxt = best_start_r;
    best_end_nxt   = best_end_r;
    best_score_nxt = best_score_r;
    have_best_nxt  = have_best_r;
    if (advance) begin
      if (item.frame_end) begin
        cnt_nxt        = '0;
        row_nxt        = '0;
        in_band_nxt    = 1'b0;
        open_start_nxt = '0;
        open_score_nxt = '0;
        best_start_nxt = '0;
        best_end_nxt   = '0;
        best_score_nxt = '0;
        have_best_nxt  = 1'b0;
      end else if (item.row_end) begin
        cnt_nxt        = '0;
        row_nxt        = (row_r == ROW_LAST) ? '0 : row_r + 1'b1;
        in_band_nxt    = row_valid;
        if (row_valid) begin
          open_start_nxt = band_start_row;
          open_score_nxt = band_start_score;
        end
        best_start_nxt = fin_start;
        best_end_nxt   = fin_end;
        best_score_nxt = fin_score;
        have_best_nxt  = fin_have;
      end else begin
        cnt_nxt = cnt_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      row_r        <= '0;
      in_band_r    <= 1'b0;
      open_start_r <= '0;
      open_score_r <= '0;
      best_start_r <= '0;
      best_end_r   <= '0;
      best_score_r <= '0;
      have_best_r  <= 1'b0;
    end else begin
      cnt_r        <= cnt_nxt;
      row_r        <= row_nxt;
      in_band_r    <= in_band_nxt;
      open_start_r <= open_start_nxt;
      open_score_r <= open_score_nxt;
      best_start_r <= best_start_nxt;
      best_end_r   <= best_end_nxt;
      best_score_r <= best_score_nxt;
      have_best_r  <= have_best_nxt;
    end
  end

endmodule

>>> hw/rtl/bright_row_band_finder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bright_row_band_finder
// Finds the highest-scoring band of consecutive rows whose bright pixel
// count lies within a window, and reports it once per frame.
// ----------------------------------------------------------------------------
//
//   Channel  Ports                                   Moves
//   in       in_valid/in_ready, pixel, marks         one pixel request
//   out      out_valid/out_ready, band report        one report per frame
//   cfg      cfg_we, cfg_index, cfg_wdata            register write
//
// A pixel request is taken into an input register and processed from there,
// so one pixel per clock is sustained while the input side does not stall.
// The report is registered when its frame-end pixel is processed. Reset is
// synchronous, active low, and restores the register defaults and clears all
// frame state. The input side stalls only when a frame-end pixel waits in the
// input register while the previous frame's report has not yet been taken;
// other pixels keep flowing under a stalled output.
//
// Each pixel is compared with the threshold and counted for its row. At a row
// end the count is checked against the minimum and maximum; valid rows extend
// or open a band, and an invalid row closes an open band, which replaces the
// best band only when its score is strictly higher, so the earliest band wins
// a tie. At frame end the open band is closed and the best band is reported,
// with a too-tall status when its height exceeds the configured limit.
// ----------------------------------------------------------------------------
module bright_row_band_finder import brbf_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEF,
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     in_pixel,
  input  logic                 in_row_end,
  input  logic                 in_frame_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STAT_W-1:0]    out_status,
  output logic [POS_W-1:0]     out_band_start,
  output logic [POS_W-1:0]     out_band_end,
  output logic [HGT_W-1:0]     out_band_height,
  output logic [SCORE_W-1:0]   out_band_score,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  brbf_cfg_t    cfg_r, cfg_nxt;
  logic         s1_valid_r, s1_valid_nxt;
  brbf_item_t   s1_item_r;
  logic         advance;
  brbf_result_t core_result;
  logic         out_valid_r, out_valid_nxt;
  brbf_result_t out_r;
  logic         in_take;

  // Configuration registers; every 2-bit index names a register.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (brbf_reg_t'(cfg_index))
        REG_GRAY_THRESHOLD:  cfg_nxt.gray_threshold  = cfg_wdata[PIX_W-1:0];
        REG_MIN_ROW_COUNT:   cfg_nxt.min_row_count   = cfg_wdata;
        REG_MAX_ROW_COUNT:   cfg_nxt.max_row_count   = cfg_wdata;
        REG_MAX_BAND_HEIGHT: cfg_nxt.max_band_height = cfg_wdata;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gray_threshold  <= GRAY_THRESHOLD_RST;
      cfg_r.min_row_count   <= MIN_ROW_COUNT_RST;
      cfg_r.max_row_count   <= MAX_ROW_COUNT_RST;
      cfg_r.max_band_height <= MAX_BAND_HEIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The held pixel moves on unless it ends a frame and the report slot is full.
  assign advance  = s1_valid_r && (!s1_item_r.frame_end || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance && s1_item_r.frame_end) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.pixel     <= in_pixel;
      s1_item_r.row_end   <= in_row_end;
      s1_item_r.frame_end <= in_frame_end;
    end
    if (advance && s1_item_r.frame_end) begin
      out_r <= core_result;
    end
  end

  brbf_band_core #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (s1_item_r),
    .cfg     (cfg_r),
    .result  (core_result)
  );

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_band_start  = out_r.band_start;
  assign out_band_end    = out_r.band_end;
  assign out_band_height = out_r.band_height;
  assign out_band_score  = out_r.band_score;

  // A new report appears only after a frame-end pixel was processed.
  a_report_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(advance && s1_item_r.frame_end))
    else $error("report raised without a processed frame end");

  // The input side stalls only behind a blocked frame-end pixel.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s1_item_r.frame_end && out_valid_r && !out_ready))
    else $error("input stalled without a blocked frame end");

  // A no-band report carries empty band fields.
  a_no_band_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == STATUS_NO_BAND) |->
      (out_r.band_score == '0 && out_r.band_height == '0))
    else $error("no-band report with nonzero band fields");

  // A reported band has at least one row.
  a_band_height: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != STATUS_NO_BAND) |-> (out_r.band_height != '0))
    else $error("reported band with zero height");

endmodule
